/* design/i2c_master_txn_queue_sequencer_core_assert.svh */
// Assertion macros shared by the sequencer RTL.
// All of them sample on clock and are disabled while reset is high.
`ifndef I2C_MASTER_TXN_QUEUE_SEQUENCER_CORE_ASSERT_SVH
`define I2C_MASTER_TXN_QUEUE_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication
`define I2CQ_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define I2CQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/i2cq_pkg.sv */
package i2cq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // request kinds (req_tuser)
   localparam logic [2:0] REQ_QREAD  = 3'd0;
   localparam logic [2:0] REQ_QWRITE = 3'd1;
   localparam logic [2:0] REQ_QWRRD  = 3'd2;
   localparam logic [2:0] REQ_EVENT  = 3'd3;
   localparam logic [2:0] REQ_KICK   = 3'd4;

   // enqueue results
   localparam logic [2:0] ENQ_OK       = 3'd0;
   localparam logic [2:0] ENQ_FULL     = 3'd1;
   localparam logic [2:0] ENQ_BAD_ADDR = 3'd2;
   localparam logic [2:0] ENQ_BAD_LEN  = 3'd3;
   localparam logic [2:0] ENQ_NOT_REQ  = 3'd4;

   // bus controller commands
   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_CLEAR = 3'd1;
   localparam logic [2:0] CMD_START = 3'd2;
   localparam logic [2:0] CMD_NACK  = 3'd3;
   localparam logic [2:0] CMD_ACK   = 3'd4;
   localparam logic [2:0] CMD_STOP  = 3'd5;

   // per-transaction status
   localparam logic [2:0] STS_SCHED     = 3'd0;
   localparam logic [2:0] STS_PENDING   = 3'd1;
   localparam logic [2:0] STS_DONE      = 3'd2;
   localparam logic [2:0] STS_START_ERR = 3'd3;
   localparam logic [2:0] STS_ADDR_NACK = 3'd4;
   localparam logic [2:0] STS_DATA_NACK = 3'd5;

   // bus status codes after masking
   localparam logic [7:0] STATUS_MASK     = 8'hF8;
   localparam logic [7:0] BS_START        = 8'h08;
   localparam logic [7:0] BS_REP_START    = 8'h10;
   localparam logic [7:0] BS_MT_SLA_ACK   = 8'h18;
   localparam logic [7:0] BS_MT_DATA_ACK  = 8'h28;
   localparam logic [7:0] BS_MR_SLA_ACK   = 8'h40;
   localparam logic [7:0] BS_MR_DATA_ACK  = 8'h50;
   localparam logic [7:0] BS_MR_DATA_NACK = 8'h58;

   localparam logic [7:0] ADDR_BAD_BIT = 8'h80;
   localparam logic [7:0] READ_BIT     = 8'h01;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_START = 2'd1,
      PH_SLA   = 2'd2,
      PH_DATA  = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0] tag;
      logic [7:0] read_len;
      logic [7:0] len;
      logic [7:0] addr_byte;
   } entry_type;

   typedef struct packed {
      logic [2:0] status_code;
      logic       status_valid;
      logic [7:0] result_tag;
      logic [7:0] buffer_index;
      logic [7:0] rx_byte_out;
      logic       store_rx_valid;
      logic       send_data_valid;
      logic [7:0] address_byte;
      logic       send_address_valid;
      logic [2:0] bus_cmd;
      logic [2:0] enqueue_result;
      logic       last;
   } rsp_word_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;      // latch the accepted request word
      logic exec;         // commit the step, load first result
      logic load_second;  // load the follow-up start result
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;
      logic two_results;
   } dp_stat_type;

endpackage

/* design/i2cq_ctrl.sv */
module i2cq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  i2cq_pkg::dp_stat_type stat,
   output i2cq_pkg::dp_cmd_type  cmd
);

   typedef enum logic [1:0] {
      CTRL_IDLE  = 2'd0,
      CTRL_EXEC  = 2'd1,
      CTRL_READ2 = 2'd2,
      CTRL_EXEC2 = 2'd3
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   assign req_tready = ready_ff;

   always_comb begin
      cmd.capture     = req_tvalid & ready_ff;
      cmd.exec        = (state_ff == CTRL_EXEC) & stat.out_free;
      cmd.load_second = (state_ff == CTRL_EXEC2) & stat.out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTRL_IDLE: begin
            if (cmd.capture) state_in = CTRL_EXEC;
         end
         CTRL_EXEC: begin
            if (cmd.exec) state_in = stat.two_results ? CTRL_READ2 : CTRL_IDLE;
         end
         CTRL_READ2: begin
            // new head is being read
            state_in = CTRL_EXEC2;
         end
         CTRL_EXEC2: begin
            if (cmd.load_second) state_in = CTRL_IDLE;
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
      ready_in = (state_in == CTRL_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

`include "i2c_master_txn_queue_sequencer_core_assert.svh"

   `I2CQ_ASSERT_NEXT(a_accept_goes_exec, cmd.capture, state_ff == CTRL_EXEC, "accept did not start execution")
   `I2CQ_ASSERT_IMP(a_ready_only_idle, ready_ff, state_ff == CTRL_IDLE, "ready outside idle")
   `I2CQ_ASSERT_NEXT(a_two_goes_read2, cmd.exec && stat.two_results, state_ff == CTRL_READ2, "second result skipped")

endmodule

/* design/i2cq_dp.sv */
module i2cq_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  i2cq_pkg::dp_cmd_type   cmd,
   output i2cq_pkg::dp_stat_type  stat,
   input  logic [47:0]            req_tdata,
   input  logic [2:0]             req_tuser,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output i2cq_pkg::rsp_word_type rsp_word
);

   // queue storage, registered read at the head
   i2cq_pkg::entry_type q_mem [i2cq_pkg::QUEUE_DEPTH];
   i2cq_pkg::entry_type rd_ff;

   logic [i2cq_pkg::PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [i2cq_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   i2cq_pkg::phase_type        phase_ff, phase_in;
   logic [7:0]                 bd_ff, bd_in;

   // latched request
   logic [2:0] typ_ff;
   logic [7:0] tag_ff, addr_ff, wlen_ff, rlen_ff, st_ff, rx_ff;

   logic                       wr_en;
   logic [i2cq_pkg::PTR_W-1:0] wr_addr;
   i2cq_pkg::entry_type        wr_data;

   i2cq_pkg::rsp_word_type r0, r1, rsp_ff;
   logic                   rsp_valid_ff;
   logic                   two;
   logic                   fin, endw;
   logic [2:0]             fin_code;
   logic [8:0]             d1, len9;
   logic [7:0]             bdw;
   logic [i2cq_pkg::PTR_W-1:0] head_next;

   assign head_next = (head_ff == i2cq_pkg::PTR_W'(i2cq_pkg::QUEUE_DEPTH - 1)) ?
                      '0 : head_ff + 1'b1;

   // entry writes land only on the executing edge
   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) q_mem[wr_addr] <= wr_data;
      rd_ff <= q_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         typ_ff  <= req_tuser;
         tag_ff  <= req_tdata[7:0];
         addr_ff <= req_tdata[15:8];
         wlen_ff <= req_tdata[23:16];
         rlen_ff <= req_tdata[31:24];
         st_ff   <= req_tdata[39:32] & i2cq_pkg::STATUS_MASK;
         rx_ff   <= req_tdata[47:40];
      end
   end

   assign d1   = {1'b0, bd_ff} + 9'd1;
   assign len9 = {1'b0, rd_ff.len};
   assign bdw  = bd_ff + 8'd1;

   always_comb begin
      r0 = '0;
      r0.enqueue_result = i2cq_pkg::ENQ_NOT_REQ;
      two      = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = tail_ff;
      wr_data  = '0;
      head_in  = head_ff;
      tail_in  = tail_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      bd_in    = bd_ff;
      fin      = 1'b0;
      fin_code = i2cq_pkg::STS_DONE;
      endw     = 1'b0;

      if (typ_ff == i2cq_pkg::REQ_QREAD || typ_ff == i2cq_pkg::REQ_QWRITE ||
          typ_ff == i2cq_pkg::REQ_QWRRD) begin
         if (cnt_ff >= i2cq_pkg::CNT_W'(i2cq_pkg::QUEUE_DEPTH)) begin
            r0.enqueue_result = i2cq_pkg::ENQ_FULL;
         end else if ((addr_ff & i2cq_pkg::ADDR_BAD_BIT) != 8'd0) begin
            r0.enqueue_result = i2cq_pkg::ENQ_BAD_ADDR;
         end else if (typ_ff != i2cq_pkg::REQ_QWRITE && rlen_ff == 8'd0) begin
            r0.enqueue_result = i2cq_pkg::ENQ_BAD_LEN;
         end else begin
            wr_en        = 1'b1;
            wr_data.tag  = tag_ff;
            if (typ_ff == i2cq_pkg::REQ_QREAD) begin
               wr_data.addr_byte = {addr_ff[6:0], 1'b0} | i2cq_pkg::READ_BIT;
               wr_data.len       = rlen_ff;
               wr_data.read_len  = rlen_ff;
            end else begin
               wr_data.addr_byte = {addr_ff[6:0], 1'b0};
               wr_data.len       = wlen_ff;
               wr_data.read_len  = (typ_ff == i2cq_pkg::REQ_QWRITE) ? 8'd0 : rlen_ff;
            end
            tail_in = (tail_ff == i2cq_pkg::PTR_W'(i2cq_pkg::QUEUE_DEPTH - 1)) ?
                      '0 : tail_ff + 1'b1;
            cnt_in  = cnt_ff + 1'b1;
            r0.enqueue_result = i2cq_pkg::ENQ_OK;
            r0.status_valid   = 1'b1;
            r0.result_tag     = tag_ff;
            r0.status_code    = i2cq_pkg::STS_SCHED;
         end
      end else if (typ_ff == i2cq_pkg::REQ_EVENT) begin
         if (cnt_ff == '0) begin
            phase_in  = i2cq_pkg::PH_IDLE;
            r0.bus_cmd = i2cq_pkg::CMD_CLEAR;
         end else if (phase_ff == i2cq_pkg::PH_START) begin
            if (st_ff != i2cq_pkg::BS_START && st_ff != i2cq_pkg::BS_REP_START) begin
               r0.status_valid = 1'b1;
               r0.result_tag   = rd_ff.tag;
               r0.status_code  = i2cq_pkg::STS_START_ERR;
               head_in = head_next;
               cnt_in  = cnt_ff - 1'b1;
               if (cnt_ff == i2cq_pkg::CNT_W'(1)) begin
                  phase_in   = i2cq_pkg::PH_IDLE;
                  r0.bus_cmd = i2cq_pkg::CMD_CLEAR;
               end else begin
                  two = 1'b1;  // restart on the next entry
               end
            end else begin
               phase_in              = i2cq_pkg::PH_SLA;
               r0.bus_cmd            = i2cq_pkg::CMD_NACK;
               r0.send_address_valid = 1'b1;
               r0.address_byte       = rd_ff.addr_byte;
               r0.result_tag         = rd_ff.tag;
            end
         end else if ((rd_ff.addr_byte & i2cq_pkg::READ_BIT) == 8'd0) begin
            // write transfer
            if (phase_ff == i2cq_pkg::PH_SLA) begin
               if (st_ff != i2cq_pkg::BS_MT_SLA_ACK) begin
                  fin = 1'b1;
                  fin_code = i2cq_pkg::STS_ADDR_NACK;
               end else begin
                  phase_in = i2cq_pkg::PH_DATA;
                  bd_in    = 8'd0;
                  if (rd_ff.len == 8'd0) begin
                     endw = 1'b1;
                  end else begin
                     r0.bus_cmd         = i2cq_pkg::CMD_NACK;
                     r0.send_data_valid = 1'b1;
                     r0.buffer_index    = 8'd0;
                     r0.result_tag      = rd_ff.tag;
                  end
               end
            end else if (phase_ff == i2cq_pkg::PH_DATA) begin
               if (st_ff != i2cq_pkg::BS_MT_DATA_ACK) begin
                  fin = 1'b1;
                  fin_code = i2cq_pkg::STS_DATA_NACK;
               end else begin
                  bd_in = bdw;
                  if (bdw >= rd_ff.len) begin
                     endw = 1'b1;
                  end else begin
                     r0.bus_cmd         = i2cq_pkg::CMD_NACK;
                     r0.send_data_valid = 1'b1;
                     r0.buffer_index    = bdw;
                     r0.result_tag      = rd_ff.tag;
                  end
               end
            end
         end else begin
            // read transfer
            if (phase_ff == i2cq_pkg::PH_SLA) begin
               if (st_ff != i2cq_pkg::BS_MR_SLA_ACK) begin
                  fin = 1'b1;
                  fin_code = i2cq_pkg::STS_ADDR_NACK;
               end else begin
                  bd_in      = 8'd0;
                  phase_in   = i2cq_pkg::PH_DATA;
                  r0.bus_cmd = (rd_ff.len > 8'd1) ? i2cq_pkg::CMD_ACK : i2cq_pkg::CMD_NACK;
               end
            end else if (phase_ff == i2cq_pkg::PH_DATA) begin
               if ((d1 >= len9 && st_ff != i2cq_pkg::BS_MR_DATA_NACK) ||
                   (d1 < len9 && st_ff != i2cq_pkg::BS_MR_DATA_ACK)) begin
                  fin = 1'b1;
                  fin_code = i2cq_pkg::STS_DATA_NACK;
               end else begin
                  bd_in = d1[7:0];
                  if (d1 >= len9) begin
                     fin = 1'b1;
                  end else begin
                     r0.bus_cmd = ((d1 + 9'd1) < len9) ? i2cq_pkg::CMD_ACK :
                                                         i2cq_pkg::CMD_NACK;
                     r0.result_tag = rd_ff.tag;
                  end
                  r0.store_rx_valid = 1'b1;
                  r0.rx_byte_out    = rx_ff;
                  r0.buffer_index   = bd_ff;
               end
            end
         end
      end else if (typ_ff == i2cq_pkg::REQ_KICK) begin
         if (phase_ff == i2cq_pkg::PH_IDLE && cnt_ff != '0) begin
            phase_in        = i2cq_pkg::PH_START;
            r0.bus_cmd      = i2cq_pkg::CMD_START;
            r0.status_valid = 1'b1;
            r0.result_tag   = rd_ff.tag;
            r0.status_code  = i2cq_pkg::STS_PENDING;
         end
      end

      // end of write part: repeated start into the read part, or stop
      if (endw) begin
         if (rd_ff.read_len != 8'd0) begin
            r0.bus_cmd        = i2cq_pkg::CMD_START;
            wr_en             = 1'b1;
            wr_addr           = head_ff;
            wr_data.tag       = rd_ff.tag;
            wr_data.read_len  = rd_ff.read_len;
            wr_data.len       = rd_ff.read_len;
            wr_data.addr_byte = rd_ff.addr_byte | i2cq_pkg::READ_BIT;
            phase_in          = i2cq_pkg::PH_START;
         end else begin
            fin = 1'b1;
         end
      end

      if (fin) begin
         r0.bus_cmd      = i2cq_pkg::CMD_STOP;
         r0.status_valid = 1'b1;
         r0.result_tag   = rd_ff.tag;
         r0.status_code  = fin_code;
         head_in  = head_next;
         cnt_in   = cnt_ff - 1'b1;
         phase_in = i2cq_pkg::PH_IDLE;
      end

      r0.last = ~two;
   end

   always_comb begin
      r1 = '0;
      r1.enqueue_result = i2cq_pkg::ENQ_NOT_REQ;
      r1.bus_cmd        = i2cq_pkg::CMD_START;
      r1.status_valid   = 1'b1;
      r1.result_tag     = rd_ff.tag;
      r1.status_code    = i2cq_pkg::STS_PENDING;
      r1.last           = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         cnt_ff   <= '0;
         phase_ff <= i2cq_pkg::PH_IDLE;
         bd_ff    <= 8'd0;
      end else if (cmd.exec) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
         bd_ff    <= bd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.exec || cmd.load_second) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_ff <= r0;
      end else if (cmd.load_second) begin
         rsp_ff <= r1;
      end
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_word         = rsp_ff;
   assign stat.out_free    = ~rsp_valid_ff | rsp_tready;
   assign stat.two_results = two;

`include "i2c_master_txn_queue_sequencer_core_assert.svh"

   `I2CQ_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_ff <= i2cq_pkg::CNT_W'(i2cq_pkg::QUEUE_DEPTH), "entry count overflow")
   `I2CQ_ASSERT_IMP(a_empty_ptrs, cnt_ff == '0, head_ff == tail_ff, "empty queue with unequal pointers")
   `I2CQ_ASSERT_IMP(a_restart_needs_entry, cmd.exec && two, cnt_ff > i2cq_pkg::CNT_W'(1), "restart with no entry left")

endmodule

/* design/i2c_master_txn_queue_sequencer_core.sv */
// I2C master transaction sequencer. Software queues read, write and
// write-then-read transactions (up to 64 entries, each with a tag, a 7-bit
// address and byte counts); a kick starts the head transaction, and bus
// controller events then step it through start, address, data, repeated
// start and stop. Every request word returns one result word, or two when a
// start failure drops the head and another entry is restarted right away; the
// final word of a request carries rsp_tlast. The block only names buffer
// positions; the data bytes live outside. Sequence: a request word is accepted,
// then executed against the head entry read from the queue memory once the
// result register is free, and the block is ready again in the cycle after its
// last result is loaded; a restart result first needs a second head read, as
// the queue memory's read port is registered. A result held by a stalled rsp_tready
// holds execution of the next request, not its acceptance.
module i2c_master_txn_queue_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // txn_tag, slave_address, write_length, read_length, bus_status, rx_byte
   input  logic [47:0] req_tdata,
   // req_type
   input  logic [2:0]  req_tuser,
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // enqueue_result, bus_cmd, send_address_valid, address_byte,
   // send_data_valid, store_rx_valid, rx_byte_out, buffer_index,
   // result_tag, status_valid, status_code, 3 zero pad bits
   output logic [47:0] rsp_tdata,
   output logic        rsp_tlast
);

   i2cq_pkg::dp_cmd_type   cmd;
   i2cq_pkg::dp_stat_type  stat;
   i2cq_pkg::rsp_word_type rsp_word;

   // sequencing: accept, execute, optional restart read
   i2cq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // queue memory, pointers, phase and output register
   i2cq_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_word   (rsp_word)
   );

   assign rsp_tdata = {3'b000,
                       rsp_word.status_code,
                       rsp_word.status_valid,
                       rsp_word.result_tag,
                       rsp_word.buffer_index,
                       rsp_word.rx_byte_out,
                       rsp_word.store_rx_valid,
                       rsp_word.send_data_valid,
                       rsp_word.address_byte,
                       rsp_word.send_address_valid,
                       rsp_word.bus_cmd,
                       rsp_word.enqueue_result};
   assign rsp_tlast = rsp_word.last;

endmodule
